// ===== rtl/core/npps_pkg.sv =====
package npps_pkg;

    // fixed field widths of the item and result channels
    localparam int COORD_W = 24;
    localparam int INDEX_W = 16;
    localparam int DIST_W  = 50;
    localparam int SQ_W    = 2 * COORD_W;

    // size of the index space carried on the result channel
    localparam int INDEX_RANGE = 1 << INDEX_W;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // stages after the queue that can hold a path point: squares, sum, result
    localparam int BACK_SLOTS = 3;

    // largest squared distance, three times the largest squared axis offset
    localparam logic [DIST_W-1:0] DIST_MAX = 50'd844424829468675;

    typedef enum logic
    {
        OP_TARGET = 1'b0,
        OP_POINT  = 1'b1
    } opcode_t;

    // one classified path point as it travels from front to back
    typedef struct packed
    {
        logic [COORD_W-1:0] abs_dx;
        logic [COORD_W-1:0] abs_dy;
        logic [COORD_W-1:0] abs_dz;
        logic [INDEX_W-1:0] index;
        logic               overflow;
        logic               last;
    } point_t;

endpackage

// ===== rtl/core/npps_if.sv =====
interface npps_item_if;
    import npps_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      opcode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_point;

    modport source
    (
        output valid, opcode, coord_x, coord_y, coord_z, last_point,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, coord_x, coord_y, coord_z, last_point,
        output ready
    );
endinterface

interface npps_result_if;
    import npps_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] nearest_index;
    logic [DIST_W-1:0]  nearest_dist_sq;
    logic               count_overflow;

    modport source
    (
        output valid, nearest_index, nearest_dist_sq, count_overflow,
        input  ready
    );

    modport sink
    (
        input  valid, nearest_index, nearest_dist_sq, count_overflow,
        output ready
    );
endinterface

// ===== rtl/core/npps_front.sv =====
module npps_front
#(
    parameter int MAX_POINTS = 65536,
    parameter int COORD_BITS = 24
)
(
    input  logic             clk,
    input  logic             rst_n,
    npps_item_if.sink        item,
    output logic             push_valid,
    input  logic             push_ready,
    output npps_pkg::point_t push_data
);
    import npps_pkg::*;

    localparam int SHIFT     = COORD_W - COORD_BITS;
    localparam int IDX_LIMIT = (MAX_POINTS < INDEX_RANGE) ? MAX_POINTS : INDEX_RANGE;
    localparam logic [INDEX_W:0] LIMIT_C = (INDEX_W + 1)'(IDX_LIMIT);

    logic signed [COORD_W-1:0] target_x_reg, target_x_next;
    logic signed [COORD_W-1:0] target_y_reg, target_y_next;
    logic signed [COORD_W-1:0] target_z_reg, target_z_next;
    logic [INDEX_W-1:0]        counter_reg, counter_next;
    logic                      slot_used_reg, slot_used_next;
    logic                      overflow_reg, overflow_next;

    logic signed [COORD_W-1:0] ext_x, ext_y, ext_z;
    logic                      is_point;
    logic                      take_target;
    logic                      take_point;
    logic                      overflow_now;
    logic [INDEX_W:0]          counter_inc;

    // keep the low COORD_BITS bits and sign-extend from the top one of them
    function automatic logic signed [COORD_W-1:0] sext(input logic [COORD_W-1:0] v);
        logic signed [COORD_W-1:0] shl;
        shl = $signed(v << SHIFT);
        return shl >>> SHIFT;
    endfunction

    function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        if (d[COORD_W])
        begin
            d = (COORD_W + 1)'(-d);
        end
        return d[COORD_W-1:0];
    endfunction

    assign ext_x = sext(item.coord_x);
    assign ext_y = sext(item.coord_y);
    assign ext_z = sext(item.coord_z);

    assign is_point    = (item.opcode == OP_POINT);
    assign item.ready  = push_ready;
    assign push_valid  = item.valid && is_point;
    assign take_point  = item.valid && push_ready && is_point;
    assign take_target = item.valid && push_ready && !is_point;

    assign overflow_now = overflow_reg || slot_used_reg;
    assign counter_inc  = {1'b0, counter_reg} + (INDEX_W + 1)'(1);

    assign push_data.abs_dx   = abs_diff(ext_x, target_x_reg);
    assign push_data.abs_dy   = abs_diff(ext_y, target_y_reg);
    assign push_data.abs_dz   = abs_diff(ext_z, target_z_reg);
    assign push_data.index    = counter_reg;
    assign push_data.overflow = overflow_now;
    assign push_data.last     = item.last_point;

    always_comb
    begin
        target_x_next  = target_x_reg;
        target_y_next  = target_y_reg;
        target_z_next  = target_z_reg;
        counter_next   = counter_reg;
        slot_used_next = slot_used_reg;
        overflow_next  = overflow_reg;
        if (take_target)
        begin
            target_x_next = ext_x;
            target_y_next = ext_y;
            target_z_next = ext_z;
        end
        if (take_point)
        begin
            if (item.last_point)
            begin
                counter_next   = '0;
                slot_used_next = 1'b0;
                overflow_next  = 1'b0;
            end
            else
            begin
                overflow_next = overflow_now;
                if (counter_inc < LIMIT_C)
                begin
                    counter_next = counter_inc[INDEX_W-1:0];
                end
                else
                begin
                    slot_used_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            target_z_reg  <= '0;
            counter_reg   <= '0;
            slot_used_reg <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            target_x_reg  <= target_x_next;
            target_y_reg  <= target_y_next;
            target_z_reg  <= target_z_next;
            counter_reg   <= counter_next;
            slot_used_reg <= slot_used_next;
            overflow_reg  <= overflow_next;
        end
    end

endmodule

// ===== rtl/core/npps_queue.sv =====
module npps_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  npps_pkg::point_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output npps_pkg::point_t pop_data
);
    import npps_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    point_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/npps_back.sv =====
module npps_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  npps_pkg::point_t pop_data,
    npps_result_if.source    result
);
    import npps_pkg::*;

    // squares stage
    logic               s1_valid_reg, s1_valid_next;
    logic [SQ_W-1:0]    s1_sqx_reg, s1_sqy_reg, s1_sqz_reg;
    logic [INDEX_W-1:0] s1_index_reg;
    logic               s1_overflow_reg;
    logic               s1_last_reg;

    // sum stage
    logic               s2_valid_reg, s2_valid_next;
    logic [DIST_W-1:0]  s2_dist_reg;
    logic [INDEX_W-1:0] s2_index_reg;
    logic               s2_overflow_reg;
    logic               s2_last_reg;

    // running best
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [INDEX_W-1:0] best_index_reg, best_index_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg;
    logic [DIST_W-1:0]  out_dist_reg;
    logic               out_overflow_reg;

    logic               advance;
    logic               retire;
    logic               nearer;
    logic [DIST_W-1:0]  cand_dist;
    logic [INDEX_W-1:0] cand_index;

    // the pipe stops only when a last point meets an untaken result
    assign advance = !s2_valid_reg || !s2_last_reg || !out_valid_reg || result.ready;
    assign retire  = s2_valid_reg && advance;
    assign pop_ready = advance;

    assign s1_valid_next = advance ? pop_valid : s1_valid_reg;
    assign s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;

    assign nearer     = (s2_dist_reg < best_dist_reg);
    assign cand_dist  = nearer ? s2_dist_reg : best_dist_reg;
    assign cand_index = nearer ? s2_index_reg : best_index_reg;

    always_comb
    begin
        best_dist_next  = best_dist_reg;
        best_index_next = best_index_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        if (retire)
        begin
            if (s2_last_reg)
            begin
                best_dist_next  = '1;
                best_index_next = '0;
                out_valid_next  = 1'b1;
            end
            else
            begin
                best_dist_next  = cand_dist;
                best_index_next = cand_index;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            best_dist_reg  <= '1;
            best_index_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            best_dist_reg  <= best_dist_next;
            best_index_reg <= best_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_sqx_reg      <= SQ_W'(pop_data.abs_dx) * SQ_W'(pop_data.abs_dx);
            s1_sqy_reg      <= SQ_W'(pop_data.abs_dy) * SQ_W'(pop_data.abs_dy);
            s1_sqz_reg      <= SQ_W'(pop_data.abs_dz) * SQ_W'(pop_data.abs_dz);
            s1_index_reg    <= pop_data.index;
            s1_overflow_reg <= pop_data.overflow;
            s1_last_reg     <= pop_data.last;
            s2_dist_reg     <= DIST_W'(s1_sqx_reg) + DIST_W'(s1_sqy_reg)
                               + DIST_W'(s1_sqz_reg);
            s2_index_reg    <= s1_index_reg;
            s2_overflow_reg <= s1_overflow_reg;
            s2_last_reg     <= s1_last_reg;
        end
        if (retire && s2_last_reg)
        begin
            out_index_reg    <= cand_index;
            out_dist_reg     <= cand_dist;
            out_overflow_reg <= s2_overflow_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.nearest_index   = out_index_reg;
    assign result.nearest_dist_sq = out_dist_reg;
    assign result.count_overflow  = out_overflow_reg;

endmodule

// ===== rtl/core/nearest_path_point_search.sv =====
// channel   dir  modport          payload
// item      in   npps_item_if     opcode, coord_x, coord_y, coord_z, last_point
// result    out  npps_result_if   nearest_index, nearest_dist_sq, count_overflow
//
// one item per cycle while the queue has room; result valid comes from the result register
// path of a last point: front offsets into queue, queue pop into squares, sum, compare into result register
// rst_n is asynchronous: target cleared, best distance to all ones, queue and pipe emptied
// a held result stalls the back only when the next last point reaches the compare;
// the queue keeps the item side moving until its four entries fill
module nearest_path_point_search
#(
    parameter int MAX_POINTS = 65536,
    parameter int COORD_BITS = 24
)
(
    input  logic          clk,
    input  logic          rst_n,
    npps_item_if.sink     item,
    npps_result_if.source result
);
    import npps_pkg::*;

    logic   push_valid;
    logic   push_ready;
    point_t push_data;
    logic   pop_valid;
    logic   pop_ready;
    point_t pop_data;

    // front: target loads, sign extension, axis offsets, point indexing
    npps_front
    #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    )
    u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // short queue so front and back stall on their own
    npps_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // back: squares, sum, first strict minimum, result register
    npps_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

// ===== rtl/core/npps_checker.sv =====
module npps_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        in_opcode,
    input logic                        in_last,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [npps_pkg::INDEX_W-1:0] out_index,
    input logic [npps_pkg::DIST_W-1:0]  out_dist,
    input logic                        out_overflow
);
    import npps_pkg::*;

    localparam int MAX_PENDING = QUEUE_DEPTH + BACK_SLOTS;
    localparam int PEND_W      = $clog2(MAX_PENDING + 2);

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic              last_in;
    logic              res_out;

    assign last_in = in_valid && in_ready && (in_opcode == OP_POINT) && in_last;
    assign res_out = out_valid && out_ready;

    always_comb
    begin
        case ({last_in, res_out})
            2'b10:   pend_next = pend_reg + PEND_W'(1);
            2'b01:   pend_next = pend_reg - PEND_W'(1);
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // every result answers a last point already taken
    a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_out |-> pend_reg != '0)
        else $error("result without a pending last point");

    // queue plus back stages bound the open searches
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(MAX_PENDING))
        else $error("too many open searches");

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_dist <= DIST_MAX)
        else $error("squared distance out of range");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_index) && $stable(out_dist)
                                    && $stable(out_overflow))
        else $error("result changed while stalled");

endmodule

bind nearest_path_point_search npps_checker u_npps_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .in_opcode    (item.opcode),
    .in_last      (item.last_point),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_index    (result.nearest_index),
    .out_dist     (result.nearest_dist_sq),
    .out_overflow (result.count_overflow)
);
